### rtl/mwo_pkg.sv
`timescale 1ns / 1ps

package mwo_pkg;

  // Block constants
  localparam int unsigned FULL_SCALE       = 32767;
  localparam int unsigned CLIP_LIMIT       = 32767;
  localparam int unsigned SINE_TABLE_DEPTH = 1024;

  // Field widths
  localparam int MODE_W   = 2;
  localparam int AMP_W    = 16;
  localparam int FREQ_W   = 16;
  localparam int SAMPLE_W = 16;
  localparam int STATUS_W = 2;

  // Phase accumulators: sine phase is Q16.16 modulo 44100 units, triangle phase Q12.16.
  localparam int PHASE_W    = 32;
  localparam int TRI_W      = 28;
  localparam int FRAC_W     = 16;
  localparam int STEP_SHIFT = 10;
  localparam int STEP_W     = FREQ_W + STEP_SHIFT;
  localparam int TRI_INT_W  = TRI_W - FRAC_W;
  localparam int unsigned WRAP_UNITS = 44100;

  localparam logic [PHASE_W:0] SINE_WRAP =
    (PHASE_W + 1)'(64'(WRAP_UNITS) << FRAC_W);
  localparam logic [PHASE_W:0] HALF_WRAP =
    (PHASE_W + 1)'(64'(WRAP_UNITS) << (FRAC_W - 1));
  localparam logic [TRI_INT_W:0] TRI_PERIOD = (TRI_INT_W + 1)'(1) << TRI_INT_W;
  localparam logic [TRI_INT_W-1:0] TRI_HALF = TRI_INT_W'(1) << (TRI_INT_W - 1);

  // Sine table indexing: nearest of 4*DEPTH points around the circle.
  // idx = floor((sp*PTS + W/2) / W) with W = 44100 * 2^16, done as a shift by 16
  // and a reciprocal multiply for the division by 44100.
  localparam int unsigned SINE_PTS = 4 * SINE_TABLE_DEPTH;
  localparam int Q_W      = $clog2(SINE_PTS + 1);
  localparam int R_W      = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int N_W      = PHASE_W + Q_W;
  localparam int NSH_W    = N_W - FRAC_W;
  localparam int RECIP_K  = N_W;
  localparam logic [63:0] RECIP =
    ((64'd1 << RECIP_K) + 64'(WRAP_UNITS) - 64'd1) / 64'(WRAP_UNITS);
  localparam int QP_W     = RECIP_K + Q_W;

  // Magnitudes in Q.15
  localparam int UNITY_SHIFT = 15;
  localparam int SINE_W      = 16;
  localparam int MAG_W       = TRI_INT_W + UNITY_SHIFT;
  localparam logic [MAG_W-1:0] SQUARE_MAG = MAG_W'(1) << UNITY_SHIFT;

  // Scaling and clipping
  localparam int P_W         = MAG_W + AMP_W;
  localparam int SCALE_SHIFT = 30;
  localparam logic [63:0] CLIP_THRESH =
    (64'(CLIP_LIMIT) << SCALE_SHIFT) / 64'(FULL_SCALE);
  localparam int TH_W = $clog2(CLIP_THRESH + 64'd1);
  localparam int PT_W = (TH_W < P_W) ? TH_W : P_W;
  localparam int FS_W = $clog2(FULL_SCALE + 1);
  localparam int V_W  = (PT_W + FS_W > SCALE_SHIFT + SAMPLE_W) ?
                        (PT_W + FS_W) : (SCALE_SHIFT + SAMPLE_W);
  localparam logic [SAMPLE_W-1:0] CLIP_LIMIT_LO = SAMPLE_W'(CLIP_LIMIT);

  // Polynomial constants for the quarter-wave table
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  typedef enum logic [MODE_W-1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_SILENT   = 2'd3
  } wave_sel_t;

  typedef enum logic [STATUS_W-1:0] {
    CLIP_NONE = 2'd0,
    CLIP_HIGH = 2'd1,
    CLIP_LOW  = 2'd2
  } clip_status_t;

  // Quarter-wave entry r (0..DEPTH): round(32768 * sin(pi/2 * r / DEPTH)) from a
  // degree-11 Taylor polynomial in Q2.30 with truncating steps. Only called with
  // constant arguments, so each entry folds to a constant.
  function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (HALF_PI_Q30 * 64'(r)) / 64'(SINE_TABLE_DEPTH);
    x2 = (x * x) >> 30;
    t  = ONE_Q30 - x2 / 64'd110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    return SINE_W'((s + (64'd1 << 14)) >> 15);
  endfunction

endpackage

### rtl/mwo_if.sv
`timescale 1ns / 1ps

interface mwo_in_if;
  import mwo_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] wave_sel;
  logic [AMP_W-1:0]  amplitude;
  logic [FREQ_W-1:0] frequency;

  modport source (output valid, output wave_sel, output amplitude, output frequency,
                  input ready);
  modport sink   (input valid, input wave_sel, input amplitude, input frequency,
                  output ready);
endinterface

interface mwo_out_if;
  import mwo_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic [STATUS_W-1:0]        clip_status;

  modport source (output valid, output sample, output clip_status, input ready);
  modport sink   (input valid, input sample, input clip_status, output ready);
endinterface

### rtl/multi_waveform_oscillator_unit.sv
`timescale 1ns / 1ps

// Phase-accumulator oscillator. Each transaction on in_ch carries a wave mode,
// a Q1.15 amplitude and a Q0.16 frequency, and produces exactly one transaction
// on out_ch with a clipped signed sample and a clip status. The sample uses the
// phase held before the transaction; the phase then advances by frequency*1024
// units (sine phase wraps at 44100 units, triangle phase at 4096 units). The
// block is a seven-stage pipeline of stages 1 to 6 and the output register, and
// one transaction is taken every cycle while out_ch keeps up. The whole pipeline
// advances together, so in_ch.ready is low exactly while a finished result
// waits on out_ch with ready low. After reset both phases are zero and the
// block accepts input at once.

module multi_waveform_oscillator_unit (
  input  logic      clk,
  input  logic      rst_n,
  mwo_in_if.sink    in_ch,
  mwo_out_if.source out_ch
);
  import mwo_pkg::*;

  // Pipeline enable: every stage moves when the output register is free.
  logic adv;
  logic in_accept;

  // Phase accumulators
  logic [PHASE_W-1:0] sp_r, sp_nxt;
  logic [TRI_W-1:0]   tp_r, tp_nxt;
  logic [STEP_W-1:0]  step;
  logic [PHASE_W:0]   sp_sum;

  // Stage 1: captured item and the phase it sees
  logic                 v1_r;
  wave_sel_t            mode1_r;
  logic [AMP_W-1:0]     amp1_r;
  logic [PHASE_W-1:0]   sp1_r;
  logic [TRI_INT_W-1:0] t1_r;

  // Stage 2: scaled phase for the index, square sign, triangle level
  logic                 v2_r;
  wave_sel_t            mode2_r;
  logic [AMP_W-1:0]     amp2_r;
  logic [NSH_W-1:0]     nsh2_r, nsh2_nxt;
  logic                 sqneg2_r, sqneg2_nxt;
  logic [TRI_INT_W-1:0] level2_r, level2_nxt;
  logic [N_W-1:0]       n_full;

  // Stage 3: table point index around the circle
  logic                 v3_r;
  wave_sel_t            mode3_r;
  logic [AMP_W-1:0]     amp3_r;
  logic [Q_W-1:0]       q3_r, q3_nxt;
  logic                 sqneg3_r;
  logic [TRI_INT_W-1:0] level3_r;
  logic [QP_W-1:0]      q_prod;

  // Stage 4: folded quarter-table address and sine sign
  logic                 v4_r;
  wave_sel_t            mode4_r;
  logic [AMP_W-1:0]     amp4_r;
  logic [R_W-1:0]       r4_r, r4_nxt;
  logic                 neg4_r, neg4_nxt;
  logic                 sqneg4_r;
  logic [TRI_INT_W-1:0] level4_r;
  logic [Q_W-1:0]       idx;

  // Stage 5: wave magnitude in Q.15 and sign
  logic             v5_r;
  logic [AMP_W-1:0] amp5_r;
  logic [MAG_W-1:0] mag5_r, mag5_nxt;
  logic             neg5_r, neg5_nxt;

  // Stage 6: magnitude times amplitude
  logic           v6_r;
  logic [P_W-1:0] p6_r, p6_nxt;
  logic           neg6_r;

  // Output register
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] sample_r, sample_nxt;
  clip_status_t        status_r, status_nxt;
  logic                clip;
  logic [V_W-1:0]      v_prod;
  logic [SAMPLE_W-1:0] v_lo;

  // Quarter-wave sine table, entries 0..DEPTH, built at elaboration.
  logic [SINE_W-1:0] sine_rom [0:SINE_TABLE_DEPTH];

  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
    assign sine_rom[g] = quarter_sine(g);
  end

  assign adv       = !out_valid_r || out_ch.ready;
  assign in_accept = in_ch.valid && adv;
  assign in_ch.ready = adv;

  // Phase update: the step is below one full wrap, so one compare and subtract
  // keeps the sine phase in range; the triangle phase wraps by truncation.
  always_comb begin
    step   = {in_ch.frequency, STEP_SHIFT'(0)};
    sp_sum = (PHASE_W + 1)'(sp_r) + (PHASE_W + 1)'(step);
    if (sp_sum >= SINE_WRAP) begin
      sp_nxt = PHASE_W'(sp_sum - SINE_WRAP);
    end else begin
      sp_nxt = PHASE_W'(sp_sum);
    end
    tp_nxt = tp_r + TRI_W'(step);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
      tp_r <= '0;
    end else if (in_accept) begin
      sp_r <= sp_nxt;
      tp_r <= tp_nxt;
    end
  end

  // Stage 1 -> 2: the point index needs (sp*PTS + W/2) >> 16 before the divide
  // by 44100. The square wave is positive strictly inside the first half wave.
  // The triangle level 2048 - |t - 2048| reduces to t below the midpoint and
  // 4096 - t above it.
  always_comb begin
    n_full   = N_W'(sp1_r) * N_W'(SINE_PTS) + N_W'(HALF_WRAP);
    nsh2_nxt = n_full[N_W-1:FRAC_W];
    sqneg2_nxt = !((sp1_r != '0) && ((PHASE_W + 1)'(sp1_r) < HALF_WRAP));
    if (t1_r >= TRI_HALF) begin
      level2_nxt = TRI_INT_W'(TRI_PERIOD - (TRI_INT_W + 1)'(t1_r));
    end else begin
      level2_nxt = t1_r;
    end
  end

  // Stage 2 -> 3: divide by 44100 as a multiply by a rounded-up reciprocal; the
  // reciprocal is precise enough that no correction step is needed.
  always_comb begin
    q_prod = QP_W'(nsh2_r) * QP_W'(RECIP);
    q3_nxt = q_prod[RECIP_K +: Q_W];
  end

  // Stage 3 -> 4: wrap the index, then fold it into the quarter table. The
  // second and fourth quarters run the table backward; the lower half is negative.
  always_comb begin
    if (q3_r == Q_W'(SINE_PTS)) begin
      idx = '0;
    end else begin
      idx = q3_r;
    end
    if (idx < Q_W'(SINE_TABLE_DEPTH)) begin
      r4_nxt   = R_W'(idx);
      neg4_nxt = 1'b0;
    end else if (idx < Q_W'(2 * SINE_TABLE_DEPTH)) begin
      r4_nxt   = R_W'(Q_W'(2 * SINE_TABLE_DEPTH) - idx);
      neg4_nxt = 1'b0;
    end else if (idx < Q_W'(3 * SINE_TABLE_DEPTH)) begin
      r4_nxt   = R_W'(idx - Q_W'(2 * SINE_TABLE_DEPTH));
      neg4_nxt = 1'b1;
    end else begin
      r4_nxt   = R_W'(Q_W'(SINE_PTS) - idx);
      neg4_nxt = 1'b1;
    end
  end

  // Stage 4 -> 5: pick the wave. Silent mode gives a zero magnitude, which
  // never clips and yields a zero sample.
  always_comb begin
    case (mode4_r)
      WAVE_SINE: begin
        mag5_nxt = MAG_W'(sine_rom[r4_r]);
        neg5_nxt = neg4_r;
      end
      WAVE_SQUARE: begin
        mag5_nxt = SQUARE_MAG;
        neg5_nxt = sqneg4_r;
      end
      WAVE_TRIANGLE: begin
        mag5_nxt = MAG_W'(level4_r) << UNITY_SHIFT;
        neg5_nxt = 1'b0;
      end
      default: begin
        mag5_nxt = '0;
        neg5_nxt = 1'b0;
      end
    endcase
  end

  // Stage 5 -> 6: apply the amplitude.
  assign p6_nxt = P_W'(mag5_r) * P_W'(amp5_r);

  // Stage 6 -> output: the clip test compares against CLIP_LIMIT*2^30/FULL_SCALE,
  // so the full-scale multiply only has to cover values that pass it.
  always_comb begin
    clip   = 64'(p6_r) > CLIP_THRESH;
    v_prod = V_W'(p6_r[PT_W-1:0]) * V_W'(FULL_SCALE);
    v_lo   = v_prod[SCALE_SHIFT +: SAMPLE_W];
    if (clip) begin
      if (neg6_r) begin
        sample_nxt = SAMPLE_W'(0) - CLIP_LIMIT_LO;
        status_nxt = CLIP_LOW;
      end else begin
        sample_nxt = CLIP_LIMIT_LO;
        status_nxt = CLIP_HIGH;
      end
    end else begin
      if (neg6_r) begin
        sample_nxt = SAMPLE_W'(0) - v_lo;
      end else begin
        sample_nxt = v_lo;
      end
      status_nxt = CLIP_NONE;
    end
  end

  // Valid bits of the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_ch.valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      out_valid_r <= v6_r;
    end
  end

  // Payload of the pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      mode1_r  <= wave_sel_t'(in_ch.wave_sel);
      amp1_r   <= in_ch.amplitude;
      sp1_r    <= sp_r;
      t1_r     <= tp_r[TRI_W-1:FRAC_W];

      mode2_r  <= mode1_r;
      amp2_r   <= amp1_r;
      nsh2_r   <= nsh2_nxt;
      sqneg2_r <= sqneg2_nxt;
      level2_r <= level2_nxt;

      mode3_r  <= mode2_r;
      amp3_r   <= amp2_r;
      q3_r     <= q3_nxt;
      sqneg3_r <= sqneg2_r;
      level3_r <= level2_r;

      mode4_r  <= mode3_r;
      amp4_r   <= amp3_r;
      r4_r     <= r4_nxt;
      neg4_r   <= neg4_nxt;
      sqneg4_r <= sqneg3_r;
      level4_r <= level3_r;

      amp5_r   <= amp4_r;
      mag5_r   <= mag5_nxt;
      neg5_r   <= neg5_nxt;

      p6_r     <= p6_nxt;
      neg6_r   <= neg5_r;

      sample_r <= sample_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.sample      = sample_r;
  assign out_ch.clip_status = status_r;

endmodule

### rtl/mwo_checker.sv
`timescale 1ns / 1ps

module mwo_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [mwo_pkg::SAMPLE_W-1:0] sample,
  input logic [mwo_pkg::STATUS_W-1:0]        clip_status
);
  import mwo_pkg::*;

  // A result held back by the sink stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(clip_status))
    else $error("result changed while stalled");

  // The input side stalls exactly while a finished result waits.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow the output stall");

  // A clipped-high result carries the positive limit.
  a_clip_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (clip_status == CLIP_HIGH) |-> sample == CLIP_LIMIT_LO)
    else $error("clipped high without the positive limit");

  // A clipped-low result carries the negative limit.
  a_clip_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (clip_status == CLIP_LOW) |->
      sample == (SAMPLE_W'(0) - CLIP_LIMIT_LO))
    else $error("clipped low without the negative limit");

endmodule

bind multi_waveform_oscillator_unit mwo_checker u_mwo_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .sample      (out_ch.sample),
  .clip_status (out_ch.clip_status)
);
